// ===== rtl/ustep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ustep_pkg;

    // Frame store geometry
    localparam int FRAME_CAPACITY = 32;
    localparam int IDX_W          = $clog2(FRAME_CAPACITY);
    localparam int LEN_W          = $clog2(FRAME_CAPACITY + 1);

    // Serial divider
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Characters
    localparam logic [7:0] CH_TERM  = 8'h40;  // '@'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_FREQ  = 8'h66;  // 'f'
    localparam logic [7:0] CH_PULSE = 8'h70;  // 'p'
    localparam logic [7:0] CH_DIR   = 8'h64;  // 'd'
    localparam logic [7:0] CH_EN    = 8'h65;  // 'e'

    // Event codes
    localparam logic [2:0] EV_TIMER   = 3'd0;
    localparam logic [2:0] EV_DIR     = 3'd1;
    localparam logic [2:0] EV_EN      = 3'd2;
    localparam logic [2:0] EV_PULSES  = 3'd3;
    localparam logic [2:0] EV_ZERO    = 3'd4;
    localparam logic [2:0] EV_UNKNOWN = 3'd5;

    // Prescaler choices
    localparam logic [11:0] PSC_FAST = 12'd0;
    localparam logic [11:0] PSC_MID  = 12'd7;
    localparam logic [11:0] PSC_SLOW = 12'd4095;

    // Digit positions
    localparam logic [3:0] POS_FIRST      = 4'd1;
    localparam logic [3:0] POS_FREQ_LAST  = 4'd6;
    localparam logic [3:0] POS_PULSE_LAST = 4'd9;

    // Register map
    localparam int          ADDR_W   = 4;
    localparam logic [1:0]  REG_BASE = 2'd0;
    localparam logic [1:0]  REG_FAST = 2'd1;
    localparam logic [1:0]  REG_SLOW = 2'd2;
    localparam logic [31:0] BASE_RST = 32'd16000000;
    localparam logic [31:0] FAST_RST = 32'd10000;
    localparam logic [31:0] SLOW_RST = 32'd100;
    localparam logic [31:0] PULSE_RST = 32'd1000;

    typedef struct packed {
        logic       wr_en;
        logic       clear;
        logic [7:0] data;
    } frame_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ustep_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ustep_frame
    import ustep_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire frame_ctl_t       ctl,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [7:0]       rd_data,
    output logic      [7:0]       head0,
    output logic      [7:0]       head1,
    output logic      [LEN_W-1:0] length
);

    logic [7:0]       store_reg [FRAME_CAPACITY];
    logic [LEN_W-1:0] len_reg;
    logic             room;

    assign room = (len_reg < LEN_W'(FRAME_CAPACITY));

    // Bytes past the capacity are dropped; '@' resets the length only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int i = 0; i < FRAME_CAPACITY; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            len_reg <= '0;
        end
        else if (ctl.wr_en && room)
        begin
            store_reg[len_reg[IDX_W-1:0]] <= ctl.data;
            len_reg                       <= len_reg + 1'b1;
        end
    end

    assign rd_data = store_reg[rd_addr];
    assign head0   = store_reg[0];
    assign head1   = store_reg[1];
    assign length  = len_reg;

    a_len_cap : assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(FRAME_CAPACITY))
        else $error("frame length beyond capacity");

endmodule

`default_nettype wire

// ===== rtl/ustep_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module ustep_div
    import ustep_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       rem_next;
    logic                 ge;

    assign shifted  = {rem_reg, quo_reg[DIV_W-1]};
    assign ge       = (shifted >= {1'b0, dvs_reg});
    assign rem_next = ge ? (shifted - {1'b0, dvs_reg}) : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(DIV_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_end : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without finishing a run");

endmodule

`default_nettype wire

// ===== rtl/uart_step_pulse_command_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                 Payload
// s_axis    in   s_tvalid / s_tready       s_tdata[7:0]   rx_byte
// m_axis    out  m_tvalid / m_tready       m_tdata[111:0] event result
// apb       in   psel, penable, pwrite     paddr[3:0], pwdata / prdata (32)
//
// A byte other than '@' is taken and stored (dropped once the frame store is
// full). '@' ends the frame; with two or more bytes stored the command runs:
// 'd', 'e' and unknown commands go straight to the result, 'p' reads nine
// digits, one a cycle, and 'f' reads six digits, picks the prescaler, runs the
// 32-step serial divide (skipped for a zero frequency) and gives the result.
// s_tready is low while a command runs. A finished result waits in the output
// register while new bytes are taken; the next command stalls in its last
// state until that register is free. Reset is asynchronous and needs no
// clearing pass.
module uart_step_pulse_command_decoder
    import ustep_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [111:0]      m_tdata,   // [2:0] event_code, [14:3] prescaler,
                                              // [46:15] reload, [77:47] compare_half,
                                              // [109:78] pulse_countdown,
                                              // [110] direction_level,
                                              // [111] enable_level
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGITS,
        S_PRESCALE,
        S_DIVIDE,
        S_RESULT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] base_reg;
    logic [31:0] fast_reg;
    logic [31:0] slow_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RST;
            fast_reg <= FAST_RST;
            slow_reg <= SLOW_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_BASE: base_reg <= pwdata;
                REG_FAST: fast_reg <= pwdata;
                REG_SLOW: slow_reg <= pwdata;
                default:  ;  // no register here
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BASE: prdata = base_reg;
            REG_FAST: prdata = fast_reg;
            REG_SLOW: prdata = slow_reg;
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame store
    // ------------------------------------------------------------------
    frame_ctl_t       frame_ctl;
    logic [7:0]       rd_data;
    logic [7:0]       head0;
    logic [7:0]       head1;
    logic [LEN_W-1:0] frame_len;

    state_t      state_reg,     state_next;
    logic [31:0] acc_reg,       acc_next;
    logic [3:0]  pos_reg,       pos_next;
    logic        is_freq_reg,   is_freq_next;
    logic [2:0]  code_reg,      code_next;
    logic [11:0] psc_reg,       psc_next;
    logic [31:0] reload_reg,    reload_next;
    logic [31:0] pulse_reg,     pulse_next;
    logic        dir_reg,       dir_next;
    logic        en_reg,        en_next;
    logic        m_valid_reg,   m_valid_next;
    logic [2:0]  out_code_reg,  out_code_next;
    logic [11:0] out_psc_reg,   out_psc_next;
    logic [31:0] out_reload_reg, out_reload_next;
    logic [30:0] out_half_reg,  out_half_next;
    logic [31:0] out_count_reg, out_count_next;
    logic        out_dir_reg,   out_dir_next;
    logic        out_en_reg,    out_en_next;

    logic        accept;
    logic        is_term;
    logic [31:0] digit;
    logic [31:0] acc_sum;
    logic [3:0]  pos_last;
    logic [11:0] psc_sel;
    logic [31:0] dividend;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quo;
    logic        out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_term  = (s_tdata == CH_TERM);

    assign frame_ctl.wr_en = accept && !is_term;
    assign frame_ctl.clear = accept && is_term;
    assign frame_ctl.data  = s_tdata;

    ustep_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (frame_ctl),
        .rd_addr (IDX_W'(pos_reg)),
        .rd_data (rd_data),
        .head0   (head0),
        .head1   (head1),
        .length  (frame_len)
    );

    // ------------------------------------------------------------------
    // Digit accumulate (wraps modulo 2^32) and prescaler pick
    // ------------------------------------------------------------------
    assign digit    = {24'd0, rd_data} - {24'd0, CH_ZERO};
    assign acc_sum  = (acc_reg << 3) + (acc_reg << 1) + digit;
    assign pos_last = is_freq_reg ? POS_FREQ_LAST : POS_PULSE_LAST;

    always_comb
    begin
        if (acc_reg > fast_reg)
        begin
            psc_sel  = PSC_FAST;
            dividend = base_reg;
        end
        else if (acc_reg > slow_reg)
        begin
            psc_sel  = PSC_MID;
            dividend = base_reg >> 3;
        end
        else
        begin
            psc_sel  = PSC_SLOW;
            dividend = base_reg >> 12;
        end
    end

    assign div_start = (state_reg == S_PRESCALE) && (acc_reg != '0);

    ustep_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (acc_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        pos_next        = pos_reg;
        is_freq_next    = is_freq_reg;
        code_next       = code_reg;
        psc_next        = psc_reg;
        reload_next     = reload_reg;
        pulse_next      = pulse_reg;
        dir_next        = dir_reg;
        en_next         = en_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_code_next   = out_code_reg;
        out_psc_next    = out_psc_reg;
        out_reload_next = out_reload_reg;
        out_half_next   = out_half_reg;
        out_count_next  = out_count_reg;
        out_dir_next    = out_dir_reg;
        out_en_next     = out_en_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && is_term && (frame_len > LEN_W'(1)))
                begin
                    acc_next = '0;
                    pos_next = POS_FIRST;
                    unique case (head0)
                        CH_FREQ:
                        begin
                            is_freq_next = 1'b1;
                            state_next   = S_DIGITS;
                        end
                        CH_PULSE:
                        begin
                            is_freq_next = 1'b0;
                            state_next   = S_DIGITS;
                        end
                        CH_DIR:
                        begin
                            // '1' drives the pin low, '0' drives it high
                            if (head1 == CH_ONE)
                            begin
                                dir_next = 1'b0;
                            end
                            else if (head1 == CH_ZERO)
                            begin
                                dir_next = 1'b1;
                            end
                            code_next  = EV_DIR;
                            state_next = S_RESULT;
                        end
                        CH_EN:
                        begin
                            if (head1 == CH_ONE)
                            begin
                                en_next = 1'b0;
                            end
                            else if (head1 == CH_ZERO)
                            begin
                                en_next = 1'b1;
                            end
                            code_next  = EV_EN;
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            code_next  = EV_UNKNOWN;
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_DIGITS:
            begin
                acc_next = acc_sum;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == pos_last)
                begin
                    if (is_freq_reg)
                    begin
                        state_next = S_PRESCALE;
                    end
                    else
                    begin
                        pulse_next = acc_sum;
                        code_next  = EV_PULSES;
                        state_next = S_RESULT;
                    end
                end
            end
            S_PRESCALE:
            begin
                if (acc_reg == '0)
                begin
                    code_next  = EV_ZERO;
                    state_next = S_RESULT;
                end
                else
                begin
                    psc_next   = psc_sel;
                    code_next  = EV_TIMER;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    reload_next = div_quo;
                    state_next  = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    out_code_next = code_reg;
                    out_dir_next  = dir_reg;
                    out_en_next   = en_reg;
                    if (code_reg == EV_TIMER)
                    begin
                        out_psc_next    = psc_reg;
                        out_reload_next = reload_reg;
                        out_half_next   = reload_reg[31:1];
                        out_count_next  = pulse_reg - 32'd1;
                    end
                    else
                    begin
                        out_psc_next    = '0;
                        out_reload_next = '0;
                        out_half_next   = '0;
                        out_count_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            acc_reg        <= '0;
            pos_reg        <= POS_FIRST;
            is_freq_reg    <= 1'b0;
            code_reg       <= EV_UNKNOWN;
            psc_reg        <= '0;
            reload_reg     <= '0;
            pulse_reg      <= PULSE_RST;
            dir_reg        <= 1'b0;
            en_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
            out_code_reg   <= EV_UNKNOWN;
            out_psc_reg    <= '0;
            out_reload_reg <= '0;
            out_half_reg   <= '0;
            out_count_reg  <= '0;
            out_dir_reg    <= 1'b0;
            out_en_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            pos_reg        <= pos_next;
            is_freq_reg    <= is_freq_next;
            code_reg       <= code_next;
            psc_reg        <= psc_next;
            reload_reg     <= reload_next;
            pulse_reg      <= pulse_next;
            dir_reg        <= dir_next;
            en_reg         <= en_next;
            m_valid_reg    <= m_valid_next;
            out_code_reg   <= out_code_next;
            out_psc_reg    <= out_psc_next;
            out_reload_reg <= out_reload_next;
            out_half_reg   <= out_half_next;
            out_count_reg  <= out_count_next;
            out_dir_reg    <= out_dir_next;
            out_en_reg     <= out_en_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_en_reg, out_dir_reg, out_count_reg, out_half_reg,
                       out_reload_reg, out_psc_reg, out_code_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_div_in_state : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside the divide state");

    a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside the result state");

    a_timer_fields : assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_code_reg != EV_TIMER))
            |-> ((out_reload_reg == '0) && (out_psc_reg == '0) && (out_count_reg == '0)))
        else $error("timer fields set on a non-timer item");

endmodule

`default_nettype wire
